// ===== hw/rtl/lbps_pkg.sv =====
package lbps_pkg;

    localparam int SLOTS_PER_FRAME        = 50;
    localparam int HOLD_FRAMES_PER_SECOND = 100;
    localparam int NUM_MODE_REGS          = 4;
    localparam int CFG_DATA_W             = 16;
    localparam int CFG_INDEX_W            = 3;

    localparam logic [5:0]  SLOT_LAST  = 6'(SLOTS_PER_FRAME - 1);
    localparam logic [5:0]  FULL_DUTY  = 6'(SLOTS_PER_FRAME);
    localparam logic [10:0] HOLD_SCALE = 11'(HOLD_FRAMES_PER_SECOND);

    // Control states.
    localparam logic [1:0] CTL_RUN   = 2'd0;
    localparam logic [1:0] CTL_WAIT  = 2'd1;
    localparam logic [1:0] CTL_DELAY = 2'd2;
    localparam logic [1:0] CTL_SLEEP = 2'd3;

    // Breath phases.
    localparam logic [1:0] PH_INHALE = 2'd0;
    localparam logic [1:0] PH_HOLD1  = 2'd1;
    localparam logic [1:0] PH_EXHALE = 2'd2;
    localparam logic [1:0] PH_HOLD2  = 2'd3;

    localparam logic [2:0] MODE_FIRST = 3'd0;
    localparam logic [2:0] MODE_SLEEP = 3'd4;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODE0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY    = 3'd5;

    localparam logic [15:0] RST_MODE0    = 16'h0404;
    localparam logic [15:0] RST_MODE1    = 16'h0606;
    localparam logic [15:0] RST_MODE2    = 16'h4444;
    localparam logic [15:0] RST_MODE3    = 16'h0874;
    localparam logic [3:0]  RST_DEBOUNCE = 4'd3;
    localparam logic [15:0] RST_DELAY    = 16'd250;

    typedef struct packed {
        logic [NUM_MODE_REGS-1:0][15:0] timing;
        logic [3:0]                     debounce_frames;
        logic [15:0]                    release_delay;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  ctl;
        logic [1:0]  phase;
        logic        ramp_down;
        logic [5:0]  duty;
        logic [5:0]  slot;
        logic [10:0] frame;
        logic [3:0]  debounce_count;
        logic [15:0] delay_count;
    } state_t;

    typedef struct packed {
        logic       green_on;
        logic       red_on;
        logic       blue_on;
        logic [2:0] current_mode;
    } result_t;

    function automatic logic [3:0] phase_dur(input logic [15:0] timing, input logic [1:0] p);
        logic [3:0] d;
        case (p)
            PH_INHALE: d = timing[3:0];
            PH_HOLD1:  d = timing[7:4];
            PH_EXHALE: d = timing[11:8];
            PH_HOLD2:  d = timing[15:12];
            default:   d = timing[3:0];
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/led_breathing_phase_sequencer.sv =====
// LED breathing pacer. Each input beat is one PWM slot tick carrying the
// button level; each output beat carries the three LED levels for that slot
// and the mode in effect after it. Fifty slots make a frame; fade phases
// ramp the duty up and down, hold phases stay at full duty, and the button
// is sampled on the last slot of each frame while running.
// Both channels use valid/ready. Every input beat produces exactly one
// output beat, presented in the cycle after it is taken. The state
// update is a single pass of combinational logic between the state
// registers and the output register, so one beat is taken every cycle
// as long as the output register is empty or being drained in the same
// cycle. When the receiver stalls, the pending result holds in the output
// register and in_ready drops until it is taken; no beat is lost.
// Reset (rst_n, asynchronous, active low) loads the default timing, puts
// the block in mode 0 at the start of inhale, and empties the output
// register. Configuration writes take effect at the next clock edge and
// are meant to be issued only while no beat is in flight.
module led_breathing_phase_sequencer
    import lbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   button_pressed,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   green_on,
    output logic                   red_on,
    output logic                   blue_on,
    output logic [2:0]             current_mode
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    accept;

    lbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lbps_step u_step (
        .cur            (state_reg),
        .cfg            (cfg),
        .button_pressed (button_pressed),
        .nxt            (state_next),
        .res            (res_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign green_on     = res_reg.green_on;
    assign red_on       = res_reg.red_on;
    assign blue_on      = res_reg.blue_on;
    assign current_mode = res_reg.current_mode;

`ifndef NO_ASSERTIONS
    a_one_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({green_on, red_on, blue_on}) <= 1)
        else $error("more than one LED lit in a slot");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> current_mode <= MODE_SLEEP)
        else $error("mode out of range");

    a_wait_dark: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (state_reg.ctl == CTL_WAIT || state_reg.ctl == CTL_SLEEP)
        |=> !green_on && !red_on && !blue_on)
        else $error("LED lit while waiting for release or sleeping");

    a_counters: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.slot <= SLOT_LAST && state_reg.duty <= SLOT_LAST)
        else $error("slot or duty counter out of range");

    a_sleep_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ctl == CTL_SLEEP |-> state_reg.mode == MODE_SLEEP)
        else $error("sleeping outside the sleep mode");
`endif

endmodule

// ===== hw/rtl/lbps_cfg.sv =====
module lbps_cfg
    import lbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timing[0]       <= RST_MODE0;
            cfg_reg.timing[1]       <= RST_MODE1;
            cfg_reg.timing[2]       <= RST_MODE2;
            cfg_reg.timing[3]       <= RST_MODE3;
            cfg_reg.debounce_frames <= RST_DEBOUNCE;
            cfg_reg.release_delay   <= RST_DELAY;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MODE0:    cfg_reg.timing[0]       <= cfg_wdata;
                REG_MODE1:    cfg_reg.timing[1]       <= cfg_wdata;
                REG_MODE2:    cfg_reg.timing[2]       <= cfg_wdata;
                REG_MODE3:    cfg_reg.timing[3]       <= cfg_wdata;
                REG_DEBOUNCE: cfg_reg.debounce_frames <= cfg_wdata[3:0];
                REG_DELAY:    cfg_reg.release_delay   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/lbps_step.sv =====
module lbps_step
    import lbps_pkg::*;
(
    input  state_t  cur,
    input  cfg_t    cfg,
    input  logic    button_pressed,
    output state_t  nxt,
    output result_t res
);

    always_comb
    begin
        state_t      s;
        logic [15:0] timing;
        logic [3:0]  d;
        logic [3:0]  dk;
        logic [1:0]  p;
        logic        active;
        logic        hold;
        logic [5:0]  duty;
        logic        lit;
        logic [10:0] len;

        s      = cur;
        res    = '0;
        timing = '0;
        d      = '0;
        dk     = '0;
        p      = '0;
        active = 1'b0;
        hold   = 1'b0;
        duty   = '0;
        lit    = 1'b0;
        len    = '0;

        // The release delay runs out at the start of a tick, so the new mode
        // already plays (or sleeps) on that same tick.
        if (s.ctl == CTL_DELAY)
        begin
            if (s.delay_count == '0)
            begin
                s.mode      = (s.mode == MODE_SLEEP) ? MODE_FIRST : s.mode + 3'd1;
                s.phase     = PH_INHALE;
                s.ramp_down = 1'b0;
                s.duty      = '0;
                s.frame     = '0;
                s.slot      = '0;
                s.ctl       = (s.mode == MODE_SLEEP) ? CTL_SLEEP : CTL_RUN;
            end
            else
            begin
                s.delay_count = s.delay_count - 16'd1;
            end
        end

        case (s.ctl)
            CTL_SLEEP:
            begin
                if (button_pressed)
                    s.ctl = CTL_WAIT;
            end
            CTL_WAIT:
            begin
                if (!button_pressed)
                begin
                    s.ctl         = CTL_DELAY;
                    s.delay_count = cfg.release_delay;
                end
            end
            CTL_RUN:
            begin
                timing = cfg.timing[s.mode[1:0]];
                // Skip forward over phases whose duration is zero.
                for (int k = 0; k < 4; k++)
                begin
                    if (!active)
                    begin
                        p  = s.phase + 2'(k);
                        dk = phase_dur(timing, p);
                        if (dk != '0)
                        begin
                            active = 1'b1;
                            d      = dk;
                            if (k != 0)
                            begin
                                s.phase     = p;
                                s.ramp_down = 1'b0;
                                s.duty      = '0;
                                s.frame     = '0;
                            end
                        end
                    end
                end

                hold = s.phase[0];
                duty = hold ? FULL_DUTY : s.duty;
                lit  = (s.slot < duty);
                if (active)
                begin
                    case (s.phase)
                        PH_INHALE: res.green_on = lit;
                        PH_EXHALE: res.red_on   = lit;
                        default:   res.blue_on  = lit;
                    endcase
                end

                if (s.slot >= SLOT_LAST)
                begin
                    s.slot = '0;
                    if (button_pressed)
                    begin
                        if ({1'b0, s.debounce_count} + 5'd1 >= {1'b0, cfg.debounce_frames})
                        begin
                            s.debounce_count = '0;
                            s.ctl            = CTL_WAIT;
                        end
                        else
                        begin
                            s.debounce_count = s.debounce_count + 4'd1;
                        end
                    end
                    else
                    begin
                        s.debounce_count = '0;
                    end

                    if (s.ctl == CTL_RUN && active)
                    begin
                        len = hold ? 11'(d) * HOLD_SCALE : 11'(d);
                        if ({1'b0, s.frame} + 12'd1 < {1'b0, len})
                        begin
                            s.frame = s.frame + 11'd1;
                        end
                        else if (hold)
                        begin
                            s.phase     = s.phase + 2'd1;
                            s.ramp_down = 1'b0;
                            s.duty      = '0;
                            s.frame     = '0;
                        end
                        else
                        begin
                            s.frame = '0;
                            if (!s.ramp_down)
                            begin
                                if (s.duty < SLOT_LAST)
                                    s.duty = s.duty + 6'd1;
                                else
                                    s.ramp_down = 1'b1;
                            end
                            else if (s.duty != '0)
                            begin
                                s.duty = s.duty - 6'd1;
                            end
                            else
                            begin
                                s.phase     = s.phase + 2'd1;
                                s.ramp_down = 1'b0;
                                s.duty      = '0;
                                s.frame     = '0;
                            end
                        end
                    end
                end
                else
                begin
                    s.slot = s.slot + 6'd1;
                end
            end
            default: ;
        endcase

        res.current_mode = s.mode;
        nxt              = s;
    end

endmodule
